// ===== rtl/idp_pkg.sv =====
package idp_pkg;

    localparam int unsigned DIGIT_W  = 31;
    localparam int unsigned FRAC_W   = 30;
    localparam int unsigned FCNT_W   = 4;
    localparam int unsigned SEC_W    = 64;
    localparam int unsigned ACC_W    = 63;
    localparam int unsigned PROD_W   = 63;
    localparam int unsigned INT_W    = 32;
    localparam int unsigned CFG_W    = 32;
    localparam int unsigned CFG_IDX_W = 1;
    localparam int unsigned CH_W     = 8;

    localparam logic [DIGIT_W-1:0] DIGIT_MAX   = 31'h7FFF_FFFF;
    localparam logic [FCNT_W-1:0]  FRAC_DIGITS = 4'd9;
    localparam logic [FRAC_W-1:0]  NANO_LIMIT  = 30'd1000000000;

    localparam logic [CFG_W-1:0] YEAR_RESET   = 32'd31557600;
    localparam logic [CFG_W-1:0] MONTH_RESET  = 32'd2592000;
    localparam logic [CFG_W-1:0] SEC_PER_DAY  = 32'd86400;
    localparam logic [CFG_W-1:0] SEC_PER_HOUR = 32'd3600;
    localparam logic [CFG_W-1:0] SEC_PER_MIN  = 32'd60;
    localparam logic [CFG_W-1:0] SEC_UNIT     = 32'd1;

    localparam logic [CFG_IDX_W-1:0] CFG_YEAR  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_MONTH = 1'b1;

    localparam logic [CH_W-1:0] CH_NUL   = 8'h00;
    localparam logic [CH_W-1:0] CH_TAB   = 8'h09;
    localparam logic [CH_W-1:0] CH_CR    = 8'h0D;
    localparam logic [CH_W-1:0] CH_SPACE = 8'h20;
    localparam logic [CH_W-1:0] CH_PLUS  = 8'h2B;
    localparam logic [CH_W-1:0] CH_MINUS = 8'h2D;
    localparam logic [CH_W-1:0] CH_DOT   = 8'h2E;
    localparam logic [CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [CH_W-1:0] CH_D     = 8'h44;
    localparam logic [CH_W-1:0] CH_H     = 8'h48;
    localparam logic [CH_W-1:0] CH_M     = 8'h4D;
    localparam logic [CH_W-1:0] CH_P     = 8'h50;
    localparam logic [CH_W-1:0] CH_S     = 8'h53;
    localparam logic [CH_W-1:0] CH_T     = 8'h54;
    localparam logic [CH_W-1:0] CH_Y     = 8'h59;

    localparam int unsigned QDEPTH = 4;
    localparam int unsigned QPTR_W = 2;
    localparam int unsigned QCNT_W = 3;

    typedef enum logic [3:0] {
        CL_DIGIT,
        CL_P,
        CL_T,
        CL_Y,
        CL_M,
        CL_D,
        CL_H,
        CL_S,
        CL_DOT,
        CL_NUL,
        CL_BLANK,
        CL_MINUS,
        CL_PLUS,
        CL_OTHER
    } cls_t;

    typedef enum logic [1:0] {
        PH_FIRST,
        PH_DUR,
        PH_INT,
        PH_HALT
    } phase_t;

    typedef struct packed {
        cls_t       cls;
        logic [3:0] digit;
        logic       last;
    } tok_t;

    // 10^(9 - n): scales a fraction of n digits to nanoseconds
    function automatic logic [FRAC_W-1:0] pow10(input logic [FCNT_W-1:0] n);
        logic [FRAC_W-1:0] r;
        case (n)
            4'd0:    r = 30'd1000000000;
            4'd1:    r = 30'd100000000;
            4'd2:    r = 30'd10000000;
            4'd3:    r = 30'd1000000;
            4'd4:    r = 30'd100000;
            4'd5:    r = 30'd10000;
            4'd6:    r = 30'd1000;
            4'd7:    r = 30'd100;
            4'd8:    r = 30'd10;
            default: r = 30'd1;
        endcase
        return r;
    endfunction

endpackage

// ===== rtl/idp_if.sv =====
interface idp_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] ch;
    logic       last;

    modport source (output valid, output ch, output last, input ready);
    modport sink   (input valid, input ch, input last, output ready);
endinterface

interface idp_out_if;
    logic               valid;
    logic               ready;
    logic signed [63:0] seconds;
    logic [29:0]        nanoseconds;

    modport source (output valid, output seconds, output nanoseconds, input ready);
    modport sink   (input valid, input seconds, input nanoseconds, output ready);
endinterface

// ===== rtl/idp_front.sv =====
module idp_front (
    idp_in_if.sink          in,
    input  logic            q_ready,
    output logic            push,
    output idp_pkg::tok_t   tok
);

    assign in.ready = q_ready;
    assign push     = in.valid & q_ready;

    always_comb
    begin
        tok.last  = in.last;
        tok.digit = 4'd0;
        case (in.ch) inside
            [idp_pkg::CH_ZERO:idp_pkg::CH_NINE]:
            begin
                tok.cls   = idp_pkg::CL_DIGIT;
                tok.digit = 4'(in.ch - idp_pkg::CH_ZERO);
            end
            idp_pkg::CH_P:     tok.cls = idp_pkg::CL_P;
            idp_pkg::CH_T:     tok.cls = idp_pkg::CL_T;
            idp_pkg::CH_Y:     tok.cls = idp_pkg::CL_Y;
            idp_pkg::CH_M:     tok.cls = idp_pkg::CL_M;
            idp_pkg::CH_D:     tok.cls = idp_pkg::CL_D;
            idp_pkg::CH_H:     tok.cls = idp_pkg::CL_H;
            idp_pkg::CH_S:     tok.cls = idp_pkg::CL_S;
            idp_pkg::CH_DOT:   tok.cls = idp_pkg::CL_DOT;
            idp_pkg::CH_NUL:   tok.cls = idp_pkg::CL_NUL;
            idp_pkg::CH_SPACE,
            [idp_pkg::CH_TAB:idp_pkg::CH_CR]:
                               tok.cls = idp_pkg::CL_BLANK;
            idp_pkg::CH_MINUS: tok.cls = idp_pkg::CL_MINUS;
            idp_pkg::CH_PLUS:  tok.cls = idp_pkg::CL_PLUS;
            default:           tok.cls = idp_pkg::CL_OTHER;
        endcase
    end

endmodule

// ===== rtl/idp_queue.sv =====
module idp_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  idp_pkg::tok_t wdata,
    output logic          ready,
    input  logic          pop,
    output logic          rvalid,
    output idp_pkg::tok_t rdata
);

    idp_pkg::tok_t                  mem_reg [idp_pkg::QDEPTH];
    logic [idp_pkg::QPTR_W-1:0]     wr_ptr_reg;
    logic [idp_pkg::QPTR_W-1:0]     rd_ptr_reg;
    logic [idp_pkg::QCNT_W-1:0]     cnt_reg;
    logic [idp_pkg::QCNT_W-1:0]     cnt_next;

    assign ready  = (cnt_reg != idp_pkg::QCNT_W'(idp_pkg::QDEPTH));
    assign rvalid = (cnt_reg != '0);
    assign rdata  = mem_reg[rd_ptr_reg];

    always_comb
    begin
        case ({push, pop})
            2'b10:   cnt_next = cnt_reg + 1'b1;
            2'b01:   cnt_next = cnt_reg - 1'b1;
            default: cnt_next = cnt_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

// ===== rtl/idp_back.sv =====
module idp_back (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              q_valid,
    input  idp_pkg::tok_t                     q_tok,
    output logic                              pop,
    input  logic                              cfg_we,
    input  logic [idp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [idp_pkg::CFG_W-1:0]         cfg_data,
    idp_out_if.source                         out
);

    // configuration
    logic [idp_pkg::CFG_W-1:0]   spy_reg;
    logic [idp_pkg::CFG_W-1:0]   spm_reg;

    // parse state
    idp_pkg::phase_t             phase_reg, phase_next;
    logic                        tps_reg, tps_next;
    logic                        farm_reg, farm_next;
    logic                        rad_reg, rad_next;
    logic                        tstart_reg, tstart_next;
    logic                        tcheck_reg, tcheck_next;
    logic                        dpres_reg, dpres_next;
    logic                        neg_reg, neg_next;
    logic                        intm_reg, intm_next;
    logic [idp_pkg::DIGIT_W-1:0] dval_reg, dval_next;
    logic [idp_pkg::FRAC_W-1:0]  fval_reg, fval_next;
    logic [idp_pkg::FCNT_W-1:0]  fcnt_reg, fcnt_next;
    logic [idp_pkg::FRAC_W-1:0]  nanos_reg, nanos_next;

    // stage 1 -> stage 2
    logic                        s1_valid_reg;
    logic                        s1_last_reg;
    logic                        s1_add_reg;
    logic                        s1_intm_reg;
    logic [idp_pkg::PROD_W-1:0]  s1_prod_reg;
    logic [idp_pkg::INT_W-1:0]   s1_int_reg;
    logic [idp_pkg::FRAC_W-1:0]  s1_nanos_reg;

    // stage 2 / output
    logic [idp_pkg::ACC_W-1:0]   acc_reg;
    logic                        out_valid_reg;
    logic [idp_pkg::SEC_W-1:0]   sec_reg;
    logic [idp_pkg::FRAC_W-1:0]  ns_reg;

    logic                        adv;
    logic                        add_en;
    logic                        skip;
    logic                        do_digit;
    logic                        int_step;
    logic [idp_pkg::CFG_W-1:0]   mb;
    logic [idp_pkg::PROD_W-1:0]  prod;
    logic [idp_pkg::FRAC_W-1:0]  nscale;
    logic [34:0]                 dmac;
    logic [idp_pkg::FRAC_W-1:0]  fmac;
    logic [idp_pkg::INT_W-1:0]   int_val;
    logic [idp_pkg::SEC_W-1:0]   sum;
    logic [idp_pkg::ACC_W-1:0]   acc_upd;
    idp_pkg::cls_t               cls;

    assign adv = !out_valid_reg || out.ready;
    assign pop = q_valid && adv;
    assign cls = q_tok.cls;

    assign out.valid       = out_valid_reg;
    assign out.seconds     = sec_reg;
    assign out.nanoseconds = ns_reg;

    assign dmac   = {4'd0, dval_reg} * 35'd10 + 35'(q_tok.digit);
    assign fmac   = fval_reg * 30'd10 + 30'(q_tok.digit);
    assign prod   = idp_pkg::PROD_W'(dval_reg) * idp_pkg::PROD_W'(mb);
    assign nscale = fval_reg * idp_pkg::pow10(fcnt_reg);

    always_comb
    begin
        phase_next  = phase_reg;
        tps_next    = tps_reg;
        farm_next   = farm_reg;
        rad_next    = rad_reg;
        tstart_next = tstart_reg;
        tcheck_next = tcheck_reg;
        dpres_next  = dpres_reg;
        neg_next    = neg_reg;
        intm_next   = intm_reg;
        dval_next   = dval_reg;
        fval_next   = fval_reg;
        fcnt_next   = fcnt_reg;
        nanos_next  = nanos_reg;
        add_en      = 1'b0;
        mb          = idp_pkg::SEC_UNIT;
        skip        = 1'b0;
        do_digit    = 1'b0;
        int_step    = 1'b0;

        unique case (phase_reg)
            idp_pkg::PH_FIRST:
            begin
                if (cls == idp_pkg::CL_P)
                begin
                    phase_next  = idp_pkg::PH_DUR;
                    tcheck_next = 1'b1;
                    tstart_next = 1'b1;
                end
                else
                begin
                    phase_next = idp_pkg::PH_INT;
                    intm_next  = 1'b1;
                    int_step   = 1'b1;
                end
            end
            idp_pkg::PH_DUR:
            begin
                if (cls == idp_pkg::CL_NUL)
                begin
                    phase_next = idp_pkg::PH_HALT;
                end
                else
                begin
                    if (tcheck_reg)
                    begin
                        tcheck_next = 1'b0;
                        if (cls == idp_pkg::CL_T)
                        begin
                            tps_next = 1'b1;
                            rad_next = 1'b0;
                            skip     = 1'b1;
                        end
                    end
                    if (!skip && tstart_reg)
                    begin
                        tstart_next = 1'b0;
                        // leading dot of a fraction-only seconds field
                        if (tps_reg && cls == idp_pkg::CL_DOT)
                        begin
                            farm_next = 1'b1;
                            rad_next  = 1'b1;
                            skip      = 1'b1;
                        end
                    end
                    if (!skip)
                    begin
                        if (cls == idp_pkg::CL_DIGIT)
                        begin
                            do_digit = 1'b1;
                        end
                        else if (!dpres_reg)
                        begin
                            phase_next = idp_pkg::PH_HALT;
                        end
                        else
                        begin
                            case (cls)
                                idp_pkg::CL_Y:
                                begin
                                    add_en = 1'b1;
                                    mb     = spy_reg;
                                end
                                idp_pkg::CL_M:
                                begin
                                    add_en = 1'b1;
                                    mb     = tps_reg ? idp_pkg::SEC_PER_MIN : spm_reg;
                                end
                                idp_pkg::CL_D:
                                begin
                                    add_en = 1'b1;
                                    mb     = idp_pkg::SEC_PER_DAY;
                                end
                                idp_pkg::CL_H:
                                begin
                                    add_en = 1'b1;
                                    mb     = idp_pkg::SEC_PER_HOUR;
                                end
                                idp_pkg::CL_DOT:
                                begin
                                    add_en    = 1'b1;
                                    farm_next = 1'b1;
                                end
                                idp_pkg::CL_S:
                                begin
                                    if (farm_reg)
                                    begin
                                        nanos_next = rad_reg ? nscale : '0;
                                    end
                                    else
                                    begin
                                        add_en = 1'b1;
                                    end
                                end
                                default:
                                begin
                                end
                            endcase
                            rad_next    = (cls == idp_pkg::CL_DOT);
                            dval_next   = '0;
                            dpres_next  = 1'b0;
                            fval_next   = '0;
                            fcnt_next   = '0;
                            tstart_next = 1'b1;
                            tcheck_next = 1'b1;
                        end
                    end
                end
            end
            idp_pkg::PH_INT:
            begin
                int_step = 1'b1;
            end
            idp_pkg::PH_HALT:
            begin
            end
        endcase

        if (int_step)
        begin
            if (tstart_reg && cls == idp_pkg::CL_BLANK)
            begin
                skip = 1'b1;
            end
            else
            begin
                if (tstart_reg)
                begin
                    tstart_next = 1'b0;
                    if (cls == idp_pkg::CL_MINUS)
                    begin
                        neg_next = 1'b1;
                        skip     = 1'b1;
                    end
                    else if (cls == idp_pkg::CL_PLUS)
                    begin
                        skip = 1'b1;
                    end
                end
                if (!skip)
                begin
                    if (cls == idp_pkg::CL_DIGIT)
                    begin
                        do_digit = 1'b1;
                    end
                    else
                    begin
                        phase_next = idp_pkg::PH_HALT;
                    end
                end
            end
        end

        if (do_digit)
        begin
            dval_next  = (dmac > {4'd0, idp_pkg::DIGIT_MAX}) ? idp_pkg::DIGIT_MAX
                                                             : dmac[idp_pkg::DIGIT_W-1:0];
            dpres_next = 1'b1;
            if (fcnt_reg < idp_pkg::FRAC_DIGITS)
            begin
                fval_next = fmac;
                fcnt_next = fcnt_reg + 1'b1;
            end
        end

        int_val = neg_next ? (idp_pkg::INT_W'(0) - {1'b0, dval_next}) : {1'b0, dval_next};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spy_reg <= idp_pkg::YEAR_RESET;
            spm_reg <= idp_pkg::MONTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                idp_pkg::CFG_YEAR:  spy_reg <= cfg_data;
                idp_pkg::CFG_MONTH: spm_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    // stage 1: parse state, one character per cycle when not stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= idp_pkg::PH_FIRST;
            tps_reg    <= 1'b0;
            farm_reg   <= 1'b0;
            rad_reg    <= 1'b0;
            tstart_reg <= 1'b1;
            tcheck_reg <= 1'b0;
            dpres_reg  <= 1'b0;
            neg_reg    <= 1'b0;
            intm_reg   <= 1'b0;
            dval_reg   <= '0;
            fval_reg   <= '0;
            fcnt_reg   <= '0;
            nanos_reg  <= '0;
        end
        else if (pop)
        begin
            if (q_tok.last)
            begin
                phase_reg  <= idp_pkg::PH_FIRST;
                tps_reg    <= 1'b0;
                farm_reg   <= 1'b0;
                rad_reg    <= 1'b0;
                tstart_reg <= 1'b1;
                tcheck_reg <= 1'b0;
                dpres_reg  <= 1'b0;
                neg_reg    <= 1'b0;
                intm_reg   <= 1'b0;
                dval_reg   <= '0;
                fval_reg   <= '0;
                fcnt_reg   <= '0;
                nanos_reg  <= '0;
            end
            else
            begin
                phase_reg  <= phase_next;
                tps_reg    <= tps_next;
                farm_reg   <= farm_next;
                rad_reg    <= rad_next;
                tstart_reg <= tstart_next;
                tcheck_reg <= tcheck_next;
                dpres_reg  <= dpres_next;
                neg_reg    <= neg_next;
                intm_reg   <= intm_next;
                dval_reg   <= dval_next;
                fval_reg   <= fval_next;
                fcnt_reg   <= fcnt_next;
                nanos_reg  <= nanos_next;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s1_last_reg  <= 1'b0;
            s1_add_reg   <= 1'b0;
        end
        else if (adv)
        begin
            s1_valid_reg <= pop;
            s1_last_reg  <= q_tok.last;
            s1_add_reg   <= add_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            s1_prod_reg  <= prod;
            s1_intm_reg  <= intm_next;
            s1_int_reg   <= int_val;
            s1_nanos_reg <= nanos_next;
        end
    end

    // stage 2: saturating seconds accumulate and result register
    assign sum     = {1'b0, acc_reg} + {1'b0, s1_prod_reg};
    assign acc_upd = !s1_add_reg ? acc_reg
                   : (sum[idp_pkg::SEC_W-1] ? '1 : sum[idp_pkg::ACC_W-1:0]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= s1_valid_reg && s1_last_reg;
            if (s1_valid_reg)
            begin
                acc_reg <= s1_last_reg ? '0 : acc_upd;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && s1_valid_reg && s1_last_reg)
        begin
            sec_reg <= s1_intm_reg ? {{(idp_pkg::SEC_W - idp_pkg::INT_W){s1_int_reg[idp_pkg::INT_W-1]}},
                                      s1_int_reg}
                                   : {1'b0, acc_upd};
            ns_reg  <= s1_nanos_reg;
        end
    end

endmodule

// ===== rtl/iso8601_duration_parser_unit.sv =====
// Throughput: one character per cycle, sustained, with no gap between strings,
//   while the output is not stalled. The last character of a string goes from
//   the queue into the parse stage, then the saturating seconds add stage.
// A four-entry queue between the classifier and the parser absorbs output stalls.
// Reset (rst_n low, asynchronous): queue emptied, parse state cleared, no result
//   pending, configuration back to 365.25-day years and 30-day months.
module iso8601_duration_parser_unit (
    input  logic                              clk,
    input  logic                              rst_n,
    idp_in_if.sink                            in,
    idp_out_if.source                         out,
    input  logic                              cfg_we,
    input  logic [idp_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [idp_pkg::CFG_W-1:0]         cfg_data
);

    logic          push;
    logic          q_ready;
    logic          q_valid;
    logic          pop;
    idp_pkg::tok_t f_tok;
    idp_pkg::tok_t q_tok;

    idp_front u_front (
        .in      (in),
        .q_ready (q_ready),
        .push    (push),
        .tok     (f_tok)
    );

    idp_queue u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .push   (push),
        .wdata  (f_tok),
        .ready  (q_ready),
        .pop    (pop),
        .rvalid (q_valid),
        .rdata  (q_tok)
    );

    idp_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .q_valid   (q_valid),
        .q_tok     (q_tok),
        .pop       (pop),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .out       (out)
    );

endmodule

// ===== rtl/idp_chk.sv =====
module idp_chk (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [29:0] out_nanoseconds
);

    // strings whose last character went in but whose result has not left
    logic [2:0] pend_reg;
    logic [2:0] pend_next;
    logic       inc;
    logic       dec;

    assign inc = in_valid && in_ready && in_last;
    assign dec = out_valid && out_ready;

    always_comb
    begin
        case ({inc, dec})
            2'b10:   pend_next = pend_reg + 1'b1;
            2'b01:   pend_next = pend_reg - 1'b1;
            default: pend_next = pend_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_reg <= '0;
        end
        else
        begin
            pend_reg <= pend_next;
        end
    end

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid)
        else $error("result dropped while stalled");

    a_ns_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_nanoseconds < idp_pkg::NANO_LIMIT)
        else $error("nanoseconds out of range");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> pend_reg != 3'd0)
        else $error("result without a terminated string");

    a_pend_bound: assert property (@(posedge clk) disable iff (!rst_n)
        pend_reg <= 3'd6)
        else $error("too many strings in flight");

endmodule

bind iso8601_duration_parser_unit idp_chk u_idp_chk (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in.valid),
    .in_ready        (in.ready),
    .in_last         (in.last),
    .out_valid       (out.valid),
    .out_ready       (out.ready),
    .out_nanoseconds (out.nanoseconds)
);
